@@ design/qdr_pkg.sv @@
package qdr_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_W     = 16;
   localparam int RPM_W       = 16;
   localparam int ELAPSED_W   = 16;
   localparam int CFG_W       = 16;
   localparam int NUM_W       = COUNT_WIDTH + CFG_W;
   localparam int DEN_W       = ELAPSED_W + CFG_W;
   localparam int CNT_W       = $clog2(NUM_W);

   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_USER_W  = 1;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_W-1:0] GEARBOX_RESET   = CFG_W'(75);
   localparam logic [CFG_W-1:0] RPM_SCALE_RESET = CFG_W'(5000);

   typedef enum logic [1:0] {
      OP_SAMPLE     = 2'd0,
      OP_READ       = 2'd1,
      OP_READ_CLEAR = 2'd2,
      OP_INIT       = 2'd3
   } qdr_op_type;

   typedef enum logic [1:0] {
      REG_GEARBOX      = 2'd0,
      REG_RPM_SCALE    = 2'd1,
      REG_INVERT_LEFT  = 2'd2,
      REG_INVERT_RIGHT = 2'd3
   } qdr_reg_type;

   typedef enum logic [1:0] {
      QDR_IDLE,
      QDR_MUL,
      QDR_DIV
   } qdr_state_type;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_UP,
      STEP_DOWN
   } qdr_step_type;

   // indexed by {previous phase, current phase}
   localparam qdr_step_type STEP_TABLE [16] = '{
      STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_HOLD,
      STEP_UP,   STEP_HOLD, STEP_HOLD, STEP_DOWN,
      STEP_DOWN, STEP_HOLD, STEP_HOLD, STEP_UP,
      STEP_HOLD, STEP_UP,   STEP_DOWN, STEP_HOLD
   };

   typedef struct packed {
      logic sample;
      logic init;
      logic snap;
      logic clear;
      logic start;
   } qdr_lane_ctrl_type;

endpackage

@@ design/qdr_divider.sv @@
module qdr_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [qdr_pkg::NUM_W-1:0]            num_mag,
   input  logic                                 num_neg,
   input  logic [qdr_pkg::DEN_W-1:0]            den,
   output logic                                 done,
   output logic signed [qdr_pkg::RPM_W-1:0]     quotient
);
   import qdr_pkg::*;

   localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'((2 ** (RPM_W - 1)) - 1);
   localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(2 ** (RPM_W - 1));

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = num_mag;
         den_in  = den;
         neg_in  = num_neg;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[DEN_W] ? shifted : diff;
         quo_in = {quo_ff[NUM_W-2:0], ~diff[DEN_W]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // truncate toward zero, then saturate
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > NEG_LIMIT) begin
            quotient = {1'b1, {(RPM_W - 1){1'b0}}};
         end else begin
            quotient = -signed'(quo_ff[RPM_W-1:0]);
         end
      end else begin
         if (quo_ff > POS_LIMIT) begin
            quotient = {1'b0, {(RPM_W - 1){1'b1}}};
         end else begin
            quotient = signed'(quo_ff[RPM_W-1:0]);
         end
      end
   end

   assign done = done_ff;

endmodule

@@ design/qdr_lane.sv @@
module qdr_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qdr_pkg::qdr_lane_ctrl_type           ctrl,
   input  logic [1:0]                           phase,
   input  logic                                 invert,
   input  logic [qdr_pkg::CFG_W-1:0]            rpm_scale,
   input  logic [qdr_pkg::DEN_W-1:0]            den,
   output logic [qdr_pkg::COUNT_WIDTH-1:0]      count,
   output logic signed [qdr_pkg::RPM_W-1:0]     rpm,
   output logic                                 done
);
   import qdr_pkg::*;

   logic [1:0]             prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] snap_ff, snap_in;
   qdr_step_type           step;
   logic                   step_up;
   logic                   step_down;
   logic                   snap_neg;
   logic [COUNT_WIDTH-1:0] snap_mag;
   logic [NUM_W-1:0]       num_mag;

   always_comb begin
      step      = STEP_TABLE[{prev_ff, phase}];
      step_up   = invert ? (step == STEP_DOWN) : (step == STEP_UP);
      step_down = invert ? (step == STEP_UP) : (step == STEP_DOWN);
      prev_in   = prev_ff;
      total_in  = total_ff;
      snap_in   = ctrl.snap ? total_ff : snap_ff;
      if (ctrl.init || ctrl.clear) begin
         total_in = '0;
      end else if (ctrl.sample) begin
         if (step_up) begin
            total_in = total_ff + COUNT_WIDTH'(1);
         end else if (step_down) begin
            total_in = total_ff - COUNT_WIDTH'(1);
         end
      end
      if (ctrl.sample || ctrl.init) begin
         prev_in = phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         total_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   always_comb begin
      snap_neg = snap_ff[COUNT_WIDTH-1];
      snap_mag = snap_neg ? (~snap_ff + COUNT_WIDTH'(1)) : snap_ff;
      num_mag  = NUM_W'(snap_mag) * NUM_W'(rpm_scale);
   end

   qdr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.start),
      .num_mag  (num_mag),
      .num_neg  (snap_neg),
      .den      (den),
      .done     (done),
      .quotient (rpm)
   );

   assign count = snap_ff;

endmodule

@@ design/dual_quadrature_decoder_rpm.sv @@
// Two-channel x4 quadrature decoder with rpm readout. Pin samples and init items
// are taken one per clock, also while a read is being worked on, and give no
// result. A read item (op 1, or op 2 which also clears both counts) snapshots
// the counts on acceptance; in the next cycle each lane forms count*rpm_scale
// and the shared elapsed_ms*gearbox, and a bit-serial restoring divider in
// each lane then works out the quotient bit by bit into the output register.
// A further read is held off until that result has been taken from the output
// register. speed_error in rsp_tuser marks a zero denominator, with both rpm
// fields then zero.
module dual_quadrature_decoder_rpm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // left_a, left_b, right_a, right_b, elapsed_ms, zero fill
   input  logic [qdr_pkg::REQ_DATA_W-1:0]       req_tdata,
   // op
   input  logic [qdr_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_count, right_count, left_rpm, right_rpm
   output logic [qdr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // speed_error
   output logic [qdr_pkg::RSP_USER_W-1:0]       rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qdr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [qdr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [qdr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import qdr_pkg::*;

   logic [CFG_W-1:0]       gear_ff, gear_in;
   logic [CFG_W-1:0]       c2r_ff, c2r_in;
   logic                   inv_left_ff, inv_left_in;
   logic                   inv_right_ff, inv_right_in;
   qdr_reg_type            csr_index;
   logic                   csr_write;

   qdr_state_type          state_ff, state_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_err_ff, rsp_err_in;

   qdr_op_type             op;
   logic                   is_read;
   logic                   out_free;
   logic                   accept;
   logic [DEN_W-1:0]       den;
   qdr_lane_ctrl_type      lane_ctrl;

   logic [COUNT_WIDTH-1:0] left_count, right_count;
   logic signed [RPM_W-1:0] left_rpm, right_rpm;
   logic                   left_done, right_done;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_index  = qdr_reg_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      gear_in      = gear_ff;
      c2r_in       = c2r_ff;
      inv_left_in  = inv_left_ff;
      inv_right_in = inv_right_ff;
      if (csr_write) begin
         case (csr_index)
            REG_GEARBOX:      gear_in      = csr_pwdata[CFG_W-1:0];
            REG_RPM_SCALE:    c2r_in       = csr_pwdata[CFG_W-1:0];
            REG_INVERT_LEFT:  inv_left_in  = csr_pwdata[0];
            REG_INVERT_RIGHT: inv_right_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GEARBOX:      csr_prdata = CSR_DATA_W'(gear_ff);
         REG_RPM_SCALE:    csr_prdata = CSR_DATA_W'(c2r_ff);
         REG_INVERT_LEFT:  csr_prdata = CSR_DATA_W'(inv_left_ff);
         REG_INVERT_RIGHT: csr_prdata = CSR_DATA_W'(inv_right_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff      <= GEARBOX_RESET;
         c2r_ff       <= RPM_SCALE_RESET;
         inv_left_ff  <= 1'b1;
         inv_right_ff <= 1'b0;
      end else begin
         gear_ff      <= gear_in;
         c2r_ff       <= c2r_in;
         inv_left_ff  <= inv_left_in;
         inv_right_ff <= inv_right_in;
      end
   end

   // input handshake
   assign op         = qdr_op_type'(req_tuser);
   assign is_read    = (op == OP_READ) || (op == OP_READ_CLEAR);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !is_read || ((state_ff == QDR_IDLE) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign den        = DEN_W'(elapsed_ff) * DEN_W'(gear_ff);

   always_comb begin
      lane_ctrl.sample = accept && (op == OP_SAMPLE);
      lane_ctrl.init   = accept && (op == OP_INIT);
      lane_ctrl.snap   = accept && is_read;
      lane_ctrl.clear  = accept && (op == OP_READ_CLEAR);
      lane_ctrl.start  = (state_ff == QDR_MUL);
   end

   qdr_lane u_left (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (lane_ctrl),
      .phase         ({req_tdata[1], req_tdata[0]}),
      .invert        (inv_left_ff),
      .rpm_scale     (c2r_ff),
      .den           (den),
      .count         (left_count),
      .rpm           (left_rpm),
      .done          (left_done)
   );

   qdr_lane u_right (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (lane_ctrl),
      .phase         ({req_tdata[3], req_tdata[2]}),
      .invert        (inv_right_ff),
      .rpm_scale     (c2r_ff),
      .den           (den),
      .count         (right_count),
      .rpm           (right_rpm),
      .done          (right_done)
   );

   // sequencer and merge
   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         QDR_IDLE: begin
            if (lane_ctrl.snap) begin
               elapsed_in = req_tdata[4 +: ELAPSED_W];
               state_in   = QDR_MUL;
            end
         end
         QDR_MUL: begin
            err_in   = (den == '0);
            state_in = QDR_DIV;
         end
         QDR_DIV: begin
            if (left_done && right_done) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_data_in  = {err_ff ? RPM_W'(0) : right_rpm,
                               err_ff ? RPM_W'(0) : left_rpm,
                               FIELD_W'(right_count),
                               FIELD_W'(left_count)};
               state_in     = QDR_IDLE;
            end
         end
         default: state_in = QDR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= QDR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_err_ff);

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      left_done == right_done)
      else $error("lane dividers finished out of step");

   a_error_zero_rpm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[RSP_DATA_W-1:2*FIELD_W] == '0)
      else $error("speed error with non-zero rpm");

   a_result_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == QDR_DIV))
      else $error("result raised outside division");

   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == QDR_MUL |=> state_ff == QDR_DIV && !left_done)
      else $error("divider not started after product stage");

endmodule

@@ bench/dual_quadrature_decoder_rpm_test.sv @@
module dual_quadrature_decoder_rpm_test;
   import qdr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int STEP_DELTA [16] = '{
      0, -1, 1, 0,
      1, 0, 0, -1,
      -1, 0, 0, 1,
      0, 1, -1, 0
   };
   // phase order for one forward turn of an encoder
   localparam logic [1:0] TURN_ORDER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

   typedef struct {
      qdr_op_type op;
      logic [1:0] lphase;
      logic [1:0] rphase;
      logic [15:0] elapsed_ms;
   } item_type;

   typedef struct {
      logic [15:0] left_count;
      logic [15:0] right_count;
      logic [15:0] left_rpm;
      logic [15:0] right_rpm;
      logic speed_error;
   } reading_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   item_type pending_items [$];
   reading_type expected_readings [$];
   item_type current_item;
   int cycles = 0;
   int mismatches = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   bit hold_steady = 1'b0;

   // decoder state as the block should hold it
   logic [1:0] left_prev = 2'd0;
   logic [1:0] right_prev = 2'd0;
   logic [15:0] left_total = 16'd0;
   logic [15:0] right_total = 16'd0;
   logic [15:0] gearbox_cfg = 16'd75;
   logic [15:0] counts_cfg = 16'd5000;
   logic invert_left_cfg = 1'b1;
   logic invert_right_cfg = 1'b0;

   // encoder motion for the stimulus
   int left_pos = 0;
   int right_pos = 0;
   int left_dir = 1;
   int right_dir = 1;

   dual_quadrature_decoder_rpm uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] stepped_count(input logic [15:0] total,
                                                 input logic [1:0] prev,
                                                 input logic [1:0] cur,
                                                 input logic inv);
      int d;
      d = STEP_DELTA[{prev, cur}];
      if (inv)
         d = -d;
      return total + 16'(d);
   endfunction

   function automatic logic [15:0] rpm_of(input logic [15:0] total, input longint den);
      longint q;
      q = longint'($signed(total)) * longint'(counts_cfg) / den;
      if (q > 32767)
         q = 32767;
      else if (q < -32768)
         q = -32768;
      return q[15:0];
   endfunction

   task automatic track_item(input item_type it);
      reading_type r;
      longint den;
      case (it.op)
         OP_SAMPLE: begin
            left_total = stepped_count(left_total, left_prev, it.lphase, invert_left_cfg);
            right_total = stepped_count(right_total, right_prev, it.rphase,
                                        invert_right_cfg);
            left_prev = it.lphase;
            right_prev = it.rphase;
         end
         OP_INIT: begin
            left_prev = it.lphase;
            right_prev = it.rphase;
            left_total = 16'd0;
            right_total = 16'd0;
         end
         default: begin
            den = longint'(it.elapsed_ms) * longint'(gearbox_cfg);
            r.left_count = left_total;
            r.right_count = right_total;
            r.speed_error = (den == 0);
            if (den == 0) begin
               r.left_rpm = 16'd0;
               r.right_rpm = 16'd0;
            end else begin
               r.left_rpm = rpm_of(left_total, den);
               r.right_rpm = rpm_of(right_total, den);
            end
            expected_readings.push_back(r);
            if (it.op == OP_READ_CLEAR) begin
               left_total = 16'd0;
               right_total = 16'd0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            track_item(current_item);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               current_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'd0, current_item.elapsed_ms, current_item.rphase,
                             current_item.lphase};
               req_tuser <= current_item.op;
               if ($urandom_range(0, 149) == 0)
                  quiet = !quiet;
               if (!(quiet || hold_steady))
                  gap_left = idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("result with no read waiting");
            end else begin
               want = expected_readings.pop_front();
               check_field("left_count", rsp_tdata[15:0], want.left_count);
               check_field("right_count", rsp_tdata[31:16], want.right_count);
               check_field("left_rpm", rsp_tdata[47:32], want.left_rpm);
               check_field("right_rpm", rsp_tdata[63:48], want.right_rpm);
               check_field("speed_error", 16'(rsp_tuser[0]), 16'(want.speed_error));
            end
         end
         if (quiet || hold_steady) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = idle_length();
         end
      end
   end

   task automatic push_item(input qdr_op_type op, input logic [1:0] lphase,
                            input logic [1:0] rphase, input logic [15:0] elapsed_ms);
      item_type it;
      it.op = op;
      it.lphase = lphase;
      it.rphase = rphase;
      it.elapsed_ms = elapsed_ms;
      pending_items.push_back(it);
   endtask

   task automatic write_reg(input qdr_reg_type index, input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_GEARBOX: gearbox_cfg = value;
         REG_RPM_SCALE: counts_cfg = value;
         REG_INVERT_LEFT: invert_left_cfg = value[0];
         REG_INVERT_RIGHT: invert_right_cfg = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] gear, input logic [15:0] counts,
                             input logic inv_left, input logic inv_right);
      write_reg(REG_GEARBOX, gear);
      write_reg(REG_RPM_SCALE, counts);
      write_reg(REG_INVERT_LEFT, 16'(inv_left));
      write_reg(REG_INVERT_RIGHT, 16'(inv_right));
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_tvalid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // advance, hold, reverse or skip a phase
   task automatic move(inout int pos, inout int dir);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         pos = pos + dir;
      end else if (r < 92 && r >= 82) begin
         dir = -dir;
         pos = pos + dir;
      end else if (r >= 92) begin
         pos = pos + 2;
      end
      pos = pos & 3;
   endtask

   function automatic logic [15:0] pick_elapsed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 16'd0;
      if (r < 70)
         return 16'($urandom_range(1, 16));
      if (r < 85)
         return 16'($urandom());
      if (r < 95)
         return 16'hFFFF;
      return 16'($urandom_range(1, 255));
   endfunction

   task automatic fill_random(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            move(left_pos, left_dir);
            move(right_pos, right_dir);
            push_item(OP_SAMPLE, TURN_ORDER[left_pos], TURN_ORDER[right_pos],
                      16'($urandom()));
         end else if (r < 83) begin
            push_item(OP_SAMPLE, 2'($urandom()), 2'($urandom()), 16'($urandom()));
         end else if (r < 91) begin
            push_item(OP_READ, 2'($urandom()), 2'($urandom()), pick_elapsed());
         end else if (r < 97) begin
            push_item(OP_READ_CLEAR, 2'($urandom()), 2'($urandom()), pick_elapsed());
         end else begin
            push_item(OP_INIT, TURN_ORDER[left_pos], TURN_ORDER[right_pos],
                      16'($urandom()));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: forward turn, reverse, illegal jump, hold
      push_item(OP_INIT, 2'd0, 2'd0, 16'd0);
      push_item(OP_SAMPLE, 2'd2, 2'd2, 16'd0);
      push_item(OP_SAMPLE, 2'd3, 2'd3, 16'hFFFF);
      push_item(OP_SAMPLE, 2'd1, 2'd1, 16'd0);
      push_item(OP_SAMPLE, 2'd0, 2'd0, 16'hFFFF);
      push_item(OP_SAMPLE, 2'd1, 2'd1, 16'd0);
      push_item(OP_SAMPLE, 2'd2, 2'd2, 16'd0);
      push_item(OP_SAMPLE, 2'd2, 2'd2, 16'd0);
      push_item(OP_READ, 2'd3, 2'd3, 16'd0);
      push_item(OP_READ, 2'd3, 2'd3, 16'd1);
      push_item(OP_READ, 2'd0, 2'd0, 16'hFFFF);
      push_item(OP_READ_CLEAR, 2'd1, 2'd2, 16'd3);
      push_item(OP_READ, 2'd0, 2'd0, 16'd2);
      push_item(OP_INIT, 2'd3, 2'd2, 16'd5);
      push_item(OP_SAMPLE, 2'd3, 2'd2, 16'd0);
      push_item(OP_SAMPLE, 2'd1, 2'd3, 16'd0);
      push_item(OP_SAMPLE, 2'd0, 2'd1, 16'd0);
      push_item(OP_READ_CLEAR, 2'd0, 2'd0, 16'd1);
      drain();

      set_config(16'd1, 16'hFFFF, 1'b0, 1'b1);
      fill_random(400);
      drain();

      set_config(16'hFFFF, 16'd1, 1'b1, 1'b1);
      fill_random(400);
      drain();

      set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 1'($urandom()), 1'($urandom()));
      fill_random(400);
      drain();

      set_config(16'($urandom_range(1, 8)), 16'($urandom_range(30000, 65535)),
                 1'b0, 1'b0);
      fill_random(400);
      drain();

      // run both counts steadily, one up and one down, into rpm saturation
      hold_steady = 1'b1;
      set_config(16'd1, 16'hFFFF, 1'b1, 1'b0);
      push_item(OP_INIT, 2'd0, 2'd0, 16'd0);
      for (int i = 1; i <= 230; i++) begin
         push_item(OP_SAMPLE, TURN_ORDER[i & 3], TURN_ORDER[i & 3], 16'd0);
         if (i == 200)
            push_item(OP_READ, 2'd0, 2'd0, 16'd1);
      end
      push_item(OP_READ_CLEAR, 2'd0, 2'd0, 16'hFFFF);
      drain();
      hold_steady = 1'b0;

      if (expected_readings.size() != 0)
         report_mismatch("reads left without a result");
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
design/qdr_pkg.sv
design/qdr_divider.sv
design/qdr_lane.sv
design/dual_quadrature_decoder_rpm.sv
bench/dual_quadrature_decoder_rpm_test.sv
